// ===== sv/relay_feedback_autotuner_assert.svh =====
// Assertion macros shared by the autotuner RTL.
// Depends on a clock named aclk and an active-low reset named aresetn at the point of use.
`ifndef RELAY_FEEDBACK_AUTOTUNER_ASSERT_SVH
`define RELAY_FEEDBACK_AUTOTUNER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RFA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rfa assertion failed");

// Next-cycle implication, checked outside reset.
`define RFA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rfa assertion failed");

`endif

// ===== sv/rfa_pkg.sv =====
// Package for the relay-feedback autotuner: FSM states, register indexes and constants.
// No dependencies; used by rfa_serdiv and relay_feedback_autotuner.
package rfa_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CHECK,
        ST_MUL,
        ST_DIV_KU,
        ST_DIV_PU,
        ST_OUT
    } rfa_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rfa_div_stat_t;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAT_DRIVE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_TARGET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS   = 3'd4;

    localparam logic [14:0] SETPOINT_RST     = 15'd10000;
    localparam logic [13:0] BAND_RST         = 14'd150;
    localparam logic [7:0]  HEAT_DRIVE_RST   = 8'd200;
    localparam logic [7:0]  CYCLE_TARGET_RST = 8'd5;
    localparam logic [31:0] TIMEOUT_MS_RST   = 32'd1800000;

    localparam logic       OP_START = 1'b1;

    // Ku scale: 102400/pi in Q8 terms, and saturation of the 19-bit result
    localparam logic [15:0] KU_CONST = 16'd32595;
    localparam logic [18:0] KU_MAX   = 19'h7FFFF;

    // usable amplitude: above 0.10 degree per cycle; usable period: above 1000 ms
    localparam logic [12:0] MIN_AMP_PER_CYCLE = 13'd20;
    localparam logic [17:0] MIN_PERIOD_MS     = 18'd1000;

    localparam int unsigned DIVIDEND_W = 32;

endpackage

// ===== sv/rfa_serdiv.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on rfa_pkg and relay_feedback_autotuner_assert.svh.
`include "relay_feedback_autotuner_assert.svh"

module rfa_serdiv #(
    parameter int unsigned DVD_W = 32,
    parameter int unsigned DVS_W = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DVD_W-1:0]      dividend,
    input  logic [DVS_W-1:0]      divisor,
    output rfa_pkg::rfa_div_stat_t stat,
    output logic [DVD_W-1:0]      quotient
);
    import rfa_pkg::*;

    localparam int unsigned CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             qbit;

    // shift in the next dividend bit and try the subtraction
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

    `RFA_ASSERT_NXT(a_start_makes_busy, start, busy_reg)
    `RFA_ASSERT_IMP(a_done_ends_busy, done_reg, !busy_reg && $past(busy_reg))
    `RFA_ASSERT_IMP(a_rem_below_divisor, busy_reg, rem_reg < dvs_reg)

endmodule

// ===== sv/relay_feedback_autotuner.sv =====
// Relay-feedback autotuner: one result item for every input item.
// Start items and samples: each goes through the EVAL and OUT states before its result is
// registered; a new item is taken only once the previous result has entered the output slot.
// A finish on the cycle target adds a check and, if the measurement is usable, a multiply
// and two bit-serial divisions on the shared divider, Ku then Pu.
// Synchronous active-low reset: run stopped, registers back to their reset values,
// output empty. No clearing pass.
`include "relay_feedback_autotuner_assert.svh"

module relay_feedback_autotuner #(
    parameter int unsigned TEMP_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [rfa_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [rfa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata from bit 0: temperature[TEMP_WIDTH], now_ms[32], zero padding
    input  logic [((TEMP_WIDTH+32+7)/8)*8-1:0] s_axis_tdata,
    // tuser from bit 0: op
    input  logic [0:0]                        s_axis_tuser,
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata from bit 0: drive[8], ultimate_gain[19], ultimate_period_ms[32], zero padding
    output logic [63:0]                       m_axis_tdata,
    // tuser from bit 0: finished, success
    output logic [1:0]                        m_axis_tuser
);
    import rfa_pkg::*;

    localparam int unsigned TW     = TEMP_WIDTH;
    localparam int unsigned CMP_W  = ((TW > 15) ? TW : 15) + 2;
    localparam int unsigned SUM_W  = TW + 8;     // up to 255 crossings of TW-bit values
    localparam int unsigned SPAN_W = SUM_W + 1;

    // ---------------- configuration registers ----------------
    logic [14:0] setpoint_reg;
    logic [13:0] band_reg;
    logic [7:0]  heat_drive_reg;
    logic [7:0]  cycle_target_reg;
    logic [31:0] timeout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg     <= SETPOINT_RST;
            band_reg         <= BAND_RST;
            heat_drive_reg   <= HEAT_DRIVE_RST;
            cycle_target_reg <= CYCLE_TARGET_RST;
            timeout_reg      <= TIMEOUT_MS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SETPOINT:     setpoint_reg     <= cfg_wdata[14:0];
                CFG_BAND:         band_reg         <= cfg_wdata[13:0];
                CFG_HEAT_DRIVE:   heat_drive_reg   <= cfg_wdata[7:0];
                CFG_CYCLE_TARGET: cycle_target_reg <= cfg_wdata[7:0];
                CFG_TIMEOUT_MS:   timeout_reg      <= cfg_wdata[31:0];
                default: ;   // drop writes to unused indexes
            endcase
        end
    end

    // ---------------- state ----------------
    rfa_state_t state_reg, state_next;

    // latched input item
    logic                  op_reg, op_next;
    logic signed [TW-1:0]  temp_reg, temp_next;
    logic [31:0]           now_reg, now_next;

    // tuner state
    logic                  running_reg, running_next;
    logic                  relay_on_reg, relay_on_next;
    logic [7:0]            cycles_reg, cycles_next;
    logic [7:0]            periods_reg, periods_next;
    logic signed [TW-1:0]  peak_reg, peak_next;
    logic signed [TW-1:0]  trough_reg, trough_next;
    logic [31:0]           start_time_reg, start_time_next;
    logic [31:0]           last_cross_reg, last_cross_next;
    logic                  have_last_reg, have_last_next;
    logic signed [SUM_W-1:0] peak_sum_reg, peak_sum_next;
    logic signed [SUM_W-1:0] trough_sum_reg, trough_sum_next;
    logic [31:0]           period_sum_reg, period_sum_next;

    // finishing datapath
    logic [SUM_W-1:0]      span_reg, span_next;
    logic [15:0]           nhd_reg, nhd_next;

    // result being built
    logic [7:0]            drive_res_reg, drive_res_next;
    logic                  fin_res_reg, fin_res_next;
    logic                  ok_res_reg, ok_res_next;
    logic [18:0]           ku_res_reg, ku_res_next;
    logic [31:0]           pu_res_reg, pu_res_next;

    // output register
    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            m_drive_reg, m_drive_next;
    logic                  m_fin_reg, m_fin_next;
    logic                  m_ok_reg, m_ok_next;
    logic [18:0]           m_ku_reg, m_ku_next;
    logic [31:0]           m_pu_reg, m_pu_next;

    // shared divider
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [SUM_W-1:0]      div_divisor;
    rfa_div_stat_t         div_stat;
    logic [DIVIDEND_W-1:0] div_quotient;

    rfa_serdiv #(
        .DVD_W (DIVIDEND_W),
        .DVS_W (SUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // ---------------- per-sample arithmetic ----------------
    logic signed [CMP_W-1:0] temp_x, sp_x, band_x, hi_thr, lo_thr;
    logic [31:0]             elapsed, gap;
    logic                    timed_out;
    logic signed [TW-1:0]    peak_max, trough_min;
    logic [32:0]             psum_wide;
    logic [31:0]             psum_sat;
    logic [7:0]              cycles_inc, periods_inc, periods_after;

    assign temp_x  = {{(CMP_W-TW){temp_reg[TW-1]}}, temp_reg};
    assign sp_x    = {{(CMP_W-15){setpoint_reg[14]}}, setpoint_reg};
    assign band_x  = {{(CMP_W-14){1'b0}}, band_reg};
    assign hi_thr  = sp_x + band_x;
    assign lo_thr  = sp_x - band_x;

    // wrapped run time against the limit
    assign elapsed   = now_reg - start_time_reg;
    assign timed_out = (elapsed > timeout_reg);

    assign peak_max   = (temp_reg > peak_reg)   ? temp_reg : peak_reg;
    assign trough_min = (temp_reg < trough_reg) ? temp_reg : trough_reg;

    // crossing-to-crossing period, saturate the running sum
    assign gap       = now_reg - last_cross_reg;
    assign psum_wide = {1'b0, period_sum_reg} + {1'b0, gap};
    assign psum_sat  = psum_wide[32] ? 32'hFFFF_FFFF : psum_wide[31:0];

    assign cycles_inc    = cycles_reg + 8'd1;
    assign periods_inc   = periods_reg + 8'd1;
    assign periods_after = have_last_reg ? periods_inc : periods_reg;

    // ---------------- finishing check ----------------
    logic signed [SPAN_W-1:0] span_full;
    logic [12:0]              amp_floor;
    logic [17:0]              period_floor;
    logic                     usable;
    logic [DIVIDEND_W-1:0]    ku_num;

    assign span_full    = {peak_sum_reg[SUM_W-1], peak_sum_reg}
                        - {trough_sum_reg[SUM_W-1], trough_sum_reg};
    assign amp_floor    = 13'(cycles_reg) * MIN_AMP_PER_CYCLE;
    assign period_floor = 18'(periods_reg) * MIN_PERIOD_MS;
    assign usable       = (cycles_reg != 8'd0)
                       && (span_full > $signed({{(SPAN_W-13){1'b0}}, amp_floor}))
                       && (period_sum_reg > {14'd0, period_floor});
    assign ku_num       = 32'(nhd_reg) * 32'(KU_CONST);

    assign s_axis_tready = (state_reg == ST_IDLE);

    // ---------------- next state and outputs ----------------
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        temp_next       = temp_reg;
        now_next        = now_reg;
        running_next    = running_reg;
        relay_on_next   = relay_on_reg;
        cycles_next     = cycles_reg;
        periods_next    = periods_reg;
        peak_next       = peak_reg;
        trough_next     = trough_reg;
        start_time_next = start_time_reg;
        last_cross_next = last_cross_reg;
        have_last_next  = have_last_reg;
        peak_sum_next   = peak_sum_reg;
        trough_sum_next = trough_sum_reg;
        period_sum_next = period_sum_reg;
        span_next       = span_reg;
        nhd_next        = nhd_reg;
        drive_res_next  = drive_res_reg;
        fin_res_next    = fin_res_reg;
        ok_res_next     = ok_res_reg;
        ku_res_next     = ku_res_reg;
        pu_res_next     = pu_res_reg;
        div_start       = 1'b0;
        div_dividend    = ku_num;
        div_divisor     = span_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    op_next    = s_axis_tuser[0];
                    temp_next  = s_axis_tdata[TW-1:0];
                    now_next   = s_axis_tdata[TW+31:TW];
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL: begin
                drive_res_next = 8'd0;
                fin_res_next   = 1'b0;
                ok_res_next    = 1'b0;
                ku_res_next    = '0;
                pu_res_next    = '0;
                state_next     = ST_OUT;
                if (op_reg == OP_START) begin
                    // arm (or restart) the run
                    running_next    = 1'b1;
                    start_time_next = now_reg;
                    cycles_next     = 8'd0;
                    periods_next    = 8'd0;
                    peak_sum_next   = '0;
                    trough_sum_next = '0;
                    period_sum_next = '0;
                    last_cross_next = '0;
                    have_last_next  = 1'b0;
                    relay_on_next   = (temp_x < sp_x);
                    peak_next       = temp_reg;
                    trough_next     = temp_reg;
                end else if (running_reg) begin
                    if (timed_out) begin
                        running_next = 1'b0;
                        fin_res_next = 1'b1;
                    end else if (relay_on_reg) begin
                        peak_next = peak_max;
                        if (temp_x >= hi_thr) begin
                            relay_on_next = 1'b0;
                            trough_next   = temp_reg;
                        end else begin
                            drive_res_next = heat_drive_reg;
                        end
                    end else begin
                        trough_next = trough_min;
                        if (temp_x <= lo_thr) begin
                            // low crossing: close the cycle
                            peak_sum_next   = peak_sum_reg
                                            + {{8{peak_reg[TW-1]}}, peak_reg};
                            trough_sum_next = trough_sum_reg
                                            + {{8{trough_min[TW-1]}}, trough_min};
                            cycles_next     = cycles_inc;
                            if (have_last_reg) begin
                                period_sum_next = psum_sat;
                                periods_next    = periods_inc;
                            end
                            last_cross_next = now_reg;
                            have_last_next  = 1'b1;
                            if ((cycles_inc >= cycle_target_reg) && (periods_after != 8'd0)) begin
                                running_next = 1'b0;
                                fin_res_next = 1'b1;
                                state_next   = ST_CHECK;
                            end else begin
                                relay_on_next  = 1'b1;
                                peak_next      = temp_reg;
                                drive_res_next = heat_drive_reg;
                            end
                        end
                    end
                end
            end

            ST_CHECK: begin
                span_next = span_full[SUM_W-1:0];
                nhd_next  = 16'(cycles_reg) * 16'(heat_drive_reg);
                state_next = usable ? ST_MUL : ST_OUT;
            end

            ST_MUL: begin
                div_start  = 1'b1;   // dividend n*drive*Ku constant, divisor amplitude sum
                state_next = ST_DIV_KU;
            end

            ST_DIV_KU: begin
                if (div_stat.done) begin
                    ku_res_next  = (div_quotient > 32'(KU_MAX)) ? KU_MAX : div_quotient[18:0];
                    div_start    = 1'b1;
                    div_dividend = period_sum_reg;
                    div_divisor  = SUM_W'(periods_reg);
                    state_next   = ST_DIV_PU;
                end
            end

            ST_DIV_PU: begin
                if (div_stat.done) begin
                    pu_res_next = div_quotient;
                    ok_res_next = 1'b1;
                    state_next  = ST_OUT;
                end
            end

            ST_OUT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // output register: load the finished result when the slot is free
    always_comb begin
        m_valid_next = m_valid_reg;
        m_drive_next = m_drive_reg;
        m_fin_next   = m_fin_reg;
        m_ok_next    = m_ok_reg;
        m_ku_next    = m_ku_reg;
        m_pu_next    = m_pu_reg;
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if ((state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready)) begin
            m_valid_next = 1'b1;
            m_drive_next = drive_res_reg;
            m_fin_next   = fin_res_reg;
            m_ok_next    = ok_res_reg;
            m_ku_next    = ku_res_reg;
            m_pu_next    = pu_res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            running_reg    <= 1'b0;
            relay_on_reg   <= 1'b1;
            cycles_reg     <= 8'd0;
            periods_reg    <= 8'd0;
            peak_reg       <= {1'b1, {(TW-1){1'b0}}};
            trough_reg     <= {1'b0, {(TW-1){1'b1}}};
            start_time_reg <= '0;
            last_cross_reg <= '0;
            have_last_reg  <= 1'b0;
            peak_sum_reg   <= '0;
            trough_sum_reg <= '0;
            period_sum_reg <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            running_reg    <= running_next;
            relay_on_reg   <= relay_on_next;
            cycles_reg     <= cycles_next;
            periods_reg    <= periods_next;
            peak_reg       <= peak_next;
            trough_reg     <= trough_next;
            start_time_reg <= start_time_next;
            last_cross_reg <= last_cross_next;
            have_last_reg  <= have_last_next;
            peak_sum_reg   <= peak_sum_next;
            trough_sum_reg <= trough_sum_next;
            period_sum_reg <= period_sum_next;
        end
    end

    // payload: no reset needed
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        temp_reg      <= temp_next;
        now_reg       <= now_next;
        span_reg      <= span_next;
        nhd_reg       <= nhd_next;
        drive_res_reg <= drive_res_next;
        fin_res_reg   <= fin_res_next;
        ok_res_reg    <= ok_res_next;
        ku_res_reg    <= ku_res_next;
        pu_res_reg    <= pu_res_next;
        m_drive_reg   <= m_drive_next;
        m_fin_reg     <= m_fin_next;
        m_ok_reg      <= m_ok_next;
        m_ku_reg      <= m_ku_next;
        m_pu_reg      <= m_pu_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'd0, m_pu_reg, m_ku_reg, m_drive_reg};
    assign m_axis_tuser  = {m_ok_reg, m_fin_reg};

    `RFA_ASSERT_IMP(a_ok_needs_fin, m_valid_reg && m_ok_reg, m_fin_reg && (m_drive_reg == 8'd0))
    `RFA_ASSERT_IMP(a_fail_zero, m_valid_reg && !m_ok_reg, (m_ku_reg == '0) && (m_pu_reg == '0))
    `RFA_ASSERT_IMP(a_div_free_on_start, div_start, !div_stat.busy)
    `RFA_ASSERT_IMP(a_div_only_in_finish,
                    div_stat.busy, (state_reg == ST_DIV_KU) || (state_reg == ST_DIV_PU))

endmodule

// ===== test/tb.sv =====
// Self-checking bench for relay_feedback_autotuner: directed runs, then phases of random
// relay cycles checked against a mirror of the tuner kept in a small scoreboard class.
// Depends on rfa_pkg for register indexes, the start opcode and the Ku constants.
module tb;
    import rfa_pkg::*;

    localparam bit OP_SAMPLE    = 1'b0;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 195;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 100;
    // slowest legal run: every item a full Ku/Pu finish plus long stalls, several times over
    localparam int CYCLE_LIMIT  = 1_000_000;

    // one result item as the tuner should produce it
    typedef struct {
        logic [7:0]  drive;
        logic        finished;
        logic        success;
        logic [18:0] gain;
        logic [31:0] period;
    } tune_outcome_t;

    // Mirror of the tuner: configuration, run state and the outcomes still owed.
    class tuner_mirror;
        int          setpoint;
        int          band;
        int          heat_drive;
        int          cycle_target;
        logic [31:0] timeout_ms;
        bit          running;
        bit          relay_on;
        bit          have_cross;
        int          cycles_seen;
        int          periods_seen;
        int          cycle_peak;
        int          cycle_trough;
        logic [31:0] run_start;
        logic [31:0] last_cross;
        longint      peak_sum;
        longint      trough_sum;
        logic [31:0] period_sum;
        tune_outcome_t due[$];
        int          errors;

        function new();
            setpoint     = 10000;
            band         = 150;
            heat_drive   = 200;
            cycle_target = 5;
            timeout_ms   = 32'd1800000;
            running      = 1'b0;
            relay_on     = 1'b1;
            have_cross   = 1'b0;
            cycles_seen  = 0;
            periods_seen = 0;
            cycle_peak   = -32768;
            cycle_trough = 32767;
            run_start    = '0;
            last_cross   = '0;
            peak_sum     = 0;
            trough_sum   = 0;
            period_sum   = '0;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_SETPOINT:     setpoint = $signed(val[14:0]);
                CFG_BAND:         band = val[13:0];
                CFG_HEAT_DRIVE:   heat_drive = val[7:0];
                CFG_CYCLE_TARGET: cycle_target = val[7:0];
                CFG_TIMEOUT_MS:   timeout_ms = val;
                default: ;
            endcase
        endfunction

        // Advance the mirror by one accepted item and queue the outcome it owes.
        function void accept_item(bit op, logic [15:0] temp, logic [31:0] now);
            tune_outcome_t o;
            int            t;
            logic [31:0]   gap;
            logic [32:0]   total;
            longint        n;
            longint        m;
            longint        span;
            longint        q;
            o = '{default: '0};
            t = $signed(temp);
            if (op == OP_START) begin
                running      = 1'b1;
                run_start    = now;
                cycles_seen  = 0;
                periods_seen = 0;
                peak_sum     = 0;
                trough_sum   = 0;
                period_sum   = '0;
                last_cross   = '0;
                have_cross   = 1'b0;
                relay_on     = (t < setpoint);
                cycle_peak   = t;
                cycle_trough = t;
            end else if (running) begin
                gap = now - run_start;
                if (gap > timeout_ms) begin
                    running    = 1'b0;
                    o.finished = 1'b1;
                end else if (relay_on) begin
                    if (t > cycle_peak) cycle_peak = t;
                    if (t >= setpoint + band) begin
                        relay_on     = 1'b0;
                        cycle_trough = t;
                    end else begin
                        o.drive = heat_drive[7:0];
                    end
                end else begin
                    if (t < cycle_trough) cycle_trough = t;
                    if (t <= setpoint - band) begin
                        // low crossing: bank this cycle's extremes and the period since the last
                        peak_sum    += cycle_peak;
                        trough_sum  += cycle_trough;
                        cycles_seen  = (cycles_seen + 1) % 256;
                        if (have_cross) begin
                            gap          = now - last_cross;
                            total        = period_sum + gap;
                            period_sum   = total[32] ? '1 : total[31:0];
                            periods_seen = (periods_seen + 1) % 256;
                        end
                        last_cross = now;
                        have_cross = 1'b1;
                        if (cycles_seen >= cycle_target && periods_seen > 0) begin
                            span = peak_sum - trough_sum;
                            n    = cycles_seen;
                            m    = periods_seen;
                            if (n > 0 && span > longint'(MIN_AMP_PER_CYCLE) * n &&
                                period_sum > longint'(MIN_PERIOD_MS) * m) begin
                                q         = longint'(KU_CONST) * n * heat_drive / span;
                                o.gain    = (q > longint'(KU_MAX)) ? KU_MAX : q[18:0];
                                o.period  = period_sum / m;
                                o.success = 1'b1;
                            end
                            running    = 1'b0;
                            o.finished = 1'b1;
                        end else begin
                            relay_on   = 1'b1;
                            cycle_peak = t;
                            o.drive    = heat_drive[7:0];
                        end
                    end
                end
            end
            due.push_back(o);
        endfunction

        task report(string what);
            if (errors < 200) $display("tb: mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_outcome(logic [63:0] data, logic [1:0] flags);
            tune_outcome_t w;
            if (due.size() == 0) begin
                report($sformatf("result item %h/%b with nothing owed", data, flags));
            end else begin
                w = due.pop_front();
                if (data[7:0] !== w.drive)
                    report($sformatf("drive %0d, wanted %0d", data[7:0], w.drive));
                if (flags[0] !== w.finished)
                    report($sformatf("finished %b, wanted %b", flags[0], w.finished));
                if (flags[1] !== w.success)
                    report($sformatf("success %b, wanted %b", flags[1], w.success));
                if (data[26:8] !== w.gain)
                    report($sformatf("gain %0d, wanted %0d", data[26:8], w.gain));
                if (data[58:27] !== w.period)
                    report($sformatf("period %0d, wanted %0d", data[58:27], w.period));
            end
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata  = '0;    // temperature[16], now_ms[32]
    logic [0:0]            s_axis_tuser  = '0;    // op
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [63:0]           m_axis_tdata;          // drive[8], gain[19], period_ms[32], pad
    logic [1:0]            m_axis_tuser;          // finished, success

    tuner_mirror sb = new();

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          hold_off       = 1'b0;
    int          cycle_count    = 0;
    logic [31:0] clock_ms       = '0;
    int          cur_temp       = 0;

    relay_feedback_autotuner #(.TEMP_WIDTH(16)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog: give up well beyond the slowest legal run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Result side: stall at random, or hold off entirely while hold_off is up;
    // check every item taken against the oldest owed outcome.
    initial begin
        forever begin
            m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready)
                sb.check_outcome(m_axis_tdata, m_axis_tuser);
        end
    end

    function automatic int clamp_temp(int v);
        return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
    endfunction

    // Offer one item, idling first at random; valid stays up into the next call
    // so back-to-back items never drop it within a step.
    task automatic send_item(bit op, logic [15:0] temp, logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {now, temp};
        s_axis_tuser  <= op;
        do @(posedge aclk); while (!s_axis_tready);
        sb.accept_item(op, temp, now);
    endtask

    // Drop valid and wait until every owed result has been taken.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.due.size() != 0) @(posedge aclk);
    endtask

    // Write all five registers back to back; only call with the tuner drained.
    task automatic set_config(int sp, int bd, int hd, int ct, logic [31:0] limit_ms);
        logic [CFG_IDX_W-1:0]  regs [5];
        logic [CFG_DATA_W-1:0] vals [5];
        regs = '{CFG_SETPOINT, CFG_BAND, CFG_HEAT_DRIVE, CFG_CYCLE_TARGET, CFG_TIMEOUT_MS};
        vals = '{sp[14:0], bd[13:0], hd[7:0], ct[7:0], limit_ms};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            sb.write_reg(regs[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Arbitrary sample: any temperature, time either near the run clock or anywhere.
    task automatic noise_item();
        logic [31:0] at;
        at = $urandom_range(1) ? $urandom() : clock_ms + $urandom_range(3000, 0);
        send_item(OP_SAMPLE, 16'($urandom()), at);
    endtask

    initial begin
        int p;
        int count;
        int roll;
        int hi;
        int lo;
        int stride;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: samples while idle at the temperature and time extremes, a restart
        // mid-run, a zero cycle target ending on the second low crossing, all drive max.
        wait_drained();
        set_config(10000, 150, 255, 0, 32'hFFFF_FFFF);
        send_item(OP_SAMPLE, 16'h8000, 32'h0000_0000);
        send_item(OP_SAMPLE, 16'h7FFF, 32'hFFFF_FFFF);
        send_item(OP_START,  16'h8000, 32'h0000_0000);
        send_item(OP_SAMPLE, 16'd0,    32'd1000);
        send_item(OP_START,  16'd20000, 32'd5);
        send_item(OP_SAMPLE, 16'd9850, 32'h8000_0000);
        send_item(OP_SAMPLE, 16'h7FFF, 32'h8000_0001);
        send_item(OP_SAMPLE, 16'h8000, 32'h0000_0000);

        // Two periods of three quarters of the clock range each: the period sum saturates.
        wait_drained();
        set_config(10000, 150, 255, 3, 32'hFFFF_FFFF);
        send_item(OP_START,  16'd0,     32'd0);
        send_item(OP_SAMPLE, 16'd10150, 32'd10);
        send_item(OP_SAMPLE, 16'd9850,  32'd20);
        send_item(OP_SAMPLE, 16'd10150, 32'h6000_0000);
        send_item(OP_SAMPLE, 16'd9850,  32'hC000_0014);
        send_item(OP_SAMPLE, 16'd10150, 32'h1000_0000);
        send_item(OP_SAMPLE, 16'd9850,  32'h8000_0014);

        // Timeout across the clock wrap: exactly at the limit still runs, one past ends it.
        wait_drained();
        set_config(10000, 150, 200, 5, 32'd100);
        send_item(OP_START,  16'd0, 32'hFFFF_FFC0);
        send_item(OP_SAMPLE, 16'd0, 32'h0000_0024);
        send_item(OP_SAMPLE, 16'd0, 32'h0000_0025);

        // Crossings only a few ms apart: the run ends but the measurement is unusable.
        wait_drained();
        set_config(10000, 150, 0, 1, 32'hFFFF_FFFF);
        send_item(OP_START,  16'd10000, 32'd0);
        send_item(OP_SAMPLE, 16'd9850,  32'd5);
        send_item(OP_SAMPLE, 16'd10150, 32'd6);
        send_item(OP_SAMPLE, 16'd9850,  32'd9);
        send_item(OP_SAMPLE, 16'd0,     32'd10);

        // Random phases: mostly well-formed relay cycles steered by the mirror's relay
        // state, with some noise and restarts; each phase its own settings and idling.
        for (p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 65;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 65;
                end
                default: begin
                    send_idle_pct  = 17;
                    recv_stall_pct = 17;
                end
            endcase
            set_config((p == 1) ? -16384 : (p == 2) ? 16383
                                 : int'($urandom_range(24000, 0)) - 12000,
                       (p == 3) ? 0 : (p == 5) ? 16383 : $urandom_range(600, 5),
                       (p == 6) ? 0 : (p == 7) ? 255 : $urandom_range(254, 1),
                       (p == 8) ? 255 : (p == 9) ? 0 : $urandom_range(6, 1),
                       (p == 9) ? 32'd0 : (p == 2) ? 32'hFFFF_FFFF
                                : (p % 2) ? $urandom_range(40000, 3000)
                                : $urandom_range(32'h8000_0000, 1000000));
            clock_ms = $urandom();

            // hold the result side off long enough to back the tuner up into its input
            if (p == 4) begin
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge aclk);
                        hold_off <= 1'b0;
                    end
                join_none
            end

            count = 0;
            while (count < PHASE_ITEMS) begin
                roll = $urandom_range(99);
                if (!sb.running && roll < 30) noise_item();   // ignored while idle
                roll = $urandom_range(99);
                if (!sb.running || roll < 2) begin
                    cur_temp = clamp_temp(sb.setpoint - sb.band - 100 +
                                          int'($urandom_range(2 * sb.band + 200, 0)));
                    clock_ms += $urandom_range(500, 0);
                    send_item(OP_START, cur_temp[15:0], clock_ms);
                end else if (roll < 6) begin
                    noise_item();
                end else begin
                    // heat while the relay is on, cool while off; now and then jump
                    // straight past the threshold
                    hi = sb.setpoint + sb.band;
                    lo = sb.setpoint - sb.band;
                    if ($urandom_range(9) == 0) begin
                        cur_temp = sb.relay_on ? hi + int'($urandom_range(60, 0))
                                               : lo - int'($urandom_range(60, 0));
                    end else begin
                        stride   = $urandom_range(sb.band / 2 + 40, 1);
                        cur_temp = sb.relay_on ? cur_temp + stride : cur_temp - stride;
                    end
                    cur_temp = clamp_temp(cur_temp);
                    roll = $urandom_range(99);
                    if (roll >= 3)
                        clock_ms += (roll < 6) ? $urandom() : $urandom_range(900, 20);
                    send_item(OP_SAMPLE, cur_temp[15:0], clock_ms);
                end
                count++;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
